// ===== hdl/led_switch_matrix_scanner_defines.svh =====
// Assertion macros for the LED and switch matrix scanner.
`ifndef LED_SWITCH_MATRIX_SCANNER_DEFINES_SVH
`define LED_SWITCH_MATRIX_SCANNER_DEFINES_SVH

// Checked only outside reset.
`define LSMS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lsms assertion failed");

// Checked at every edge, reset included.
`define LSMS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("lsms assertion failed");

`endif

// ===== hdl/lsms_pkg.sv =====
// Types, codes and tables shared by the LED and switch matrix scanner.
package lsms_pkg;

  typedef enum logic [1:0] {
    OpTick  = 2'd0,
    OpWrite = 2'd1,
    OpRead  = 2'd2
  } op_e;

  localparam int unsigned SampleW  = 10;
  localparam int unsigned ReadW    = 15;
  localparam int unsigned SwABit   = 13;
  localparam int unsigned SwBBit   = 14;
  localparam int unsigned NumCols  = 8;
  localparam logic [7:0]  DutyRst  = 8'd2;
  localparam logic [7:0]  SinkRst  = 8'hFE;

  typedef struct packed {
    op_e               op;
    logic [7:0]        data_byte;
    logic              sense_a_level;
    logic              sense_b_level;
    logic [SampleW-1:0] adc_sample;
  } req_t;

  typedef struct packed {
    logic [7:0]       sink_drive;
    logic             led_enable;
    logic [ReadW-1:0] read_data;
    logic [2:0]       adc_channel;
  } rsp_t;

  function automatic logic [2:0] chan_map(input logic [2:0] step);
    logic [2:0] ch;
    case (step)
      3'd0:    ch = 3'd5;
      3'd1:    ch = 3'd3;
      3'd2:    ch = 3'd0;
      3'd3:    ch = 3'd6;
      3'd4:    ch = 3'd4;
      3'd5:    ch = 3'd2;
      3'd6:    ch = 3'd1;
      default: ch = 3'd7;
    endcase
    return ch;
  endfunction

endpackage

// ===== hdl/lsms_core.sv =====
// Scan state registers and the per-request decode that updates them.
module lsms_core #(
  parameter int unsigned ADC_BITS = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  lsms_pkg::req_t  req_i,
  input  logic [7:0]      led_on_phases_i,
  output lsms_pkg::rsp_t  rsp_o
);
  import lsms_pkg::*;

  localparam logic [SampleW-1:0] SampleMask =
    (ADC_BITS >= SampleW) ? {SampleW{1'b1}} : SampleW'((1 << ADC_BITS) - 1);

  logic [7:0] phase_q, phase_d;
  logic [7:0] pattern_q, pattern_d;
  logic [7:0] sw_a_q, sw_a_d;
  logic [7:0] sw_b_q, sw_b_d;
  logic [7:0] sink_q, sink_d;
  logic       lit_q, lit_d;

  logic [7:0] diff;
  logic [7:0] col;
  logic [2:0] step;

  always_comb begin
    phase_d   = phase_q;
    pattern_d = pattern_q;
    sw_a_d    = sw_a_q;
    sw_b_d    = sw_b_q;
    sink_d    = sink_q;
    lit_d     = lit_q;
    diff      = phase_q - led_on_phases_i;
    col       = 8'd0;
    step      = req_i.data_byte[2:0];

    rsp_o.read_data   = '0;
    rsp_o.adc_channel = '0;

    case (req_i.op)
      OpTick: begin
        phase_d = phase_q + 8'd1;
        if (phase_q == 8'd0) begin
          sink_d = ~pattern_q;
          lit_d  = 1'b1;
        end else if (phase_q == led_on_phases_i) begin
          lit_d = 1'b0;
        end else if (phase_q > led_on_phases_i) begin
          if (diff >= 8'd1 && diff <= 8'd8) begin
            col    = 8'd1 << (diff - 8'd1);
            sink_d = ~col;
            sw_a_d = req_i.sense_a_level ? (sw_a_q & ~col) : (sw_a_q | col);
          end else if (diff >= 8'd9 && diff <= 8'd16) begin
            col    = 8'd1 << (diff - 8'd9);
            sink_d = ~col;
            sw_b_d = req_i.sense_b_level ? (sw_b_q & ~col) : (sw_b_q | col);
          end
        end
      end
      OpWrite: begin
        pattern_d = req_i.data_byte;
      end
      OpRead: begin
        if (req_i.data_byte < 8'(NumCols)) begin
          rsp_o.read_data = ReadW'(req_i.adc_sample & SampleMask);
          rsp_o.read_data[SwABit] = sw_a_q[step];
          rsp_o.read_data[SwBBit] = sw_b_q[step];
          rsp_o.adc_channel = chan_map(step);
        end
      end
      default: ;
    endcase

    rsp_o.sink_drive = sink_d;
    rsp_o.led_enable = lit_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= 8'd0;
      pattern_q <= 8'd0;
      sw_a_q    <= 8'd0;
      sw_b_q    <= 8'd0;
      sink_q    <= SinkRst;
      lit_q     <= 1'b0;
    end else if (en_i) begin
      phase_q   <= phase_d;
      pattern_q <= pattern_d;
      sw_a_q    <= sw_a_d;
      sw_b_q    <= sw_b_d;
      sink_q    <= sink_d;
      lit_q     <= lit_d;
    end
  end

endmodule

// ===== hdl/led_switch_matrix_scanner.sv =====
// Top level of the LED and switch matrix scanner.
// Requests enter on in_valid_i / in_req_i and are taken at an edge where
// in_stall_o is low. op selects a tick (advance the scan phase, sample the
// sense inputs), an LED pattern write or a read of one step's ADC sample
// merged with its two switch bits. Every request gives exactly one response
// on out_valid_o / out_rsp_o, taken at an edge where out_stall_i is low.
// Responses show the sink pattern and LED enable after the request.
// A request passes the request register, then the response register.
// Throughput is one request per cycle while out_stall_i is low; the two
// registers each hold an entry, so a stalled response does not stop the
// next request from being taken until both are full.
// While out_stall_i is high the response holds; once the request register
// is also full, in_stall_o goes high.
// cfg_we_i / cfg_wdata_i write the LED-on phase count (reset 2); write it
// only when no request is in flight.
// Reset clears the phase, LED pattern and switch rows, drops the LED enable
// and leaves the first sink active.
module led_switch_matrix_scanner #(
  parameter int unsigned ADC_BITS = 10
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  lsms_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output lsms_pkg::rsp_t out_rsp_o,
  input  logic           cfg_we_i,
  input  logic [7:0]     cfg_wdata_i
);
  import lsms_pkg::*;

  logic       req_valid_q;
  req_t       req_q;
  logic       rsp_valid_q;
  rsp_t       rsp_q;
  rsp_t       rsp_d;
  logic [7:0] duty_q;
  logic       adv;
  logic       take;

  assign adv        = req_valid_q && (!rsp_valid_q || !out_stall_i);
  assign take       = in_valid_i && (!req_valid_q || adv);
  assign in_stall_o = req_valid_q && !adv;

  lsms_core #(
    .ADC_BITS (ADC_BITS)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (adv),
    .req_i           (req_q),
    .led_on_phases_i (duty_q),
    .rsp_o           (rsp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      rsp_valid_q <= 1'b0;
      duty_q      <= DutyRst;
    end else begin
      if (cfg_we_i) begin
        duty_q <= cfg_wdata_i;
      end
      if (take) begin
        req_valid_q <= 1'b1;
      end else if (adv) begin
        req_valid_q <= 1'b0;
      end
      if (adv) begin
        rsp_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      req_q <= in_req_i;
    end
    if (adv) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = rsp_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

// ===== hdl/lsms_checker.sv =====
// Port-level assertions for the LED and switch matrix scanner, with bind.
`include "led_switch_matrix_scanner_defines.svh"

module lsms_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input lsms_pkg::rsp_t out_rsp_o
);
  import lsms_pkg::*;

  logic accepted;
  assign accepted = in_valid_i && !in_stall_o;

  `LSMS_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o)
  `LSMS_ASSERT(a_out_stable, out_valid_o && out_stall_i |=> $stable(out_rsp_o))
  `LSMS_ASSERT(a_latency, accepted |-> ##2 out_valid_o)
  `LSMS_ASSERT(a_rd_gap, out_valid_o |-> out_rsp_o.read_data[12:10] == 3'd0)
  `LSMS_ASSERT_ALWAYS(a_stall_cause, in_stall_o |-> out_valid_o && out_stall_i)

endmodule

bind led_switch_matrix_scanner lsms_checker u_lsms_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);
